// ----- hw/rtl/pcmd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmd_pkg
// Shared types, register map and constant tables of the memory decoder.
// ----------------------------------------------------------------------------
package pcmd_pkg;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RAM_BANK  = 1'b0;
	localparam logic REG_CARD_TYPE = 1'b1;

	localparam logic       KIND_READ      = 1'b0;
	localparam logic       KIND_WRITE     = 1'b1;
	localparam logic [2:0] CARD_TYPE_RST  = 3'd5;
	localparam logic [2:0] CARD_NONE      = 3'd0;
	localparam logic [2:0] CARD_2K        = 3'd1;
	localparam logic [2:0] CARD_4K        = 3'd2;
	localparam logic [2:0] CARD_8K        = 3'd3;
	localparam logic [2:0] CARD_16K       = 3'd4;
	localparam logic [2:0] CARD_32K       = 3'd5;
	localparam logic [2:0] CARD_64K       = 3'd6;
	localparam logic [2:0] CARD_UNDEFINED = 3'd7;

	// Address map boundaries
	localparam logic [15:0] LCD_BASE   = 16'h2800;
	localparam logic [15:0] LCD_LAST   = 16'h2B7B;
	localparam logic [15:0] ROMSEL_LO  = 16'h3400;
	localparam logic [15:0] ROMSEL_HI  = 16'h35FF;
	localparam logic [15:0] KEY_LO     = 16'h3E00;
	localparam logic [15:0] IO_LAST    = 16'h3FFF;
	localparam logic [15:0] ROM_LAST   = 16'h7FFF;
	localparam logic [17:0] ROM_OFFSET = 18'h0C000;

	// Keyboard strobe per low nibble of the written byte
	localparam logic [7:0] KEY_STROBE_TABLE [16] = '{
		8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
		8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F
	};

	typedef struct packed {
		logic        kind;
		logic [15:0] cpu_address;
		logic [7:0]  write_data;
	} req_t;

	typedef struct packed {
		logic [17:0] physical_address;
		logic        access_ok;
		logic        lcd_dirty;
		logic [9:0]  lcd_offset;
		logic        strobe_valid;
		logic [7:0]  key_strobe;
	} rsp_t;

	// ROM bank register update from a decoded write
	typedef struct packed {
		logic       load;
		logic [2:0] value;
	} rom_wr_t;

endpackage

// ----- hw/rtl/pcmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmd_req_if / pcmd_rsp_if
// Valid/ready channels for CPU access requests and decoded results.
// ----------------------------------------------------------------------------
interface pcmd_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] cpu_address;
	logic [7:0]  write_data;

	modport source (output valid, kind, cpu_address, write_data, input ready);
	modport sink   (input valid, kind, cpu_address, write_data, output ready);
endinterface

interface pcmd_rsp_if;
	logic        valid;
	logic        ready;
	logic [17:0] physical_address;
	logic        access_ok;
	logic        lcd_dirty;
	logic [9:0]  lcd_offset;
	logic        strobe_valid;
	logic [7:0]  key_strobe;

	modport source (output valid, physical_address, access_ok, lcd_dirty, lcd_offset,
		strobe_valid, key_strobe, input ready);
	modport sink   (input valid, physical_address, access_ok, lcd_dirty, lcd_offset,
		strobe_valid, key_strobe, output ready);
endinterface

// ----- hw/rtl/pcmd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmd_decode
// Combinational decode of one CPU access: bank remap, write area decode,
// card size check, display dirty mark and keyboard strobe.
// ----------------------------------------------------------------------------
module pcmd_decode (
	input  pcmd_pkg::req_t    req,
	input  logic [2:0]        rom_bank,
	input  logic              ram_bank,
	input  logic [2:0]        card_type,
	output pcmd_pkg::rsp_t    rsp,
	output pcmd_pkg::rom_wr_t rom_wr
);
	import pcmd_pkg::*;

	logic [15:0] a;
	logic [2:0]  card_need;
	logic        card_ok;

	assign a = req.cpu_address;

	// Smallest card that covers the card RAM address
	always_comb begin
		if (ram_bank) begin
			card_need = CARD_64K;
		end else if (a[14:11] == 4'b1111) begin
			card_need = CARD_2K;
		end else if (a[14:12] == 3'b111) begin
			card_need = CARD_4K;
		end else if (a[14:13] == 2'b11) begin
			card_need = CARD_8K;
		end else if (a[14]) begin
			card_need = CARD_16K;
		end else begin
			card_need = CARD_32K;
		end
	end

	assign card_ok = (card_type != CARD_UNDEFINED) && (card_type >= card_need);

	always_comb begin
		rsp          = '0;
		rom_wr.load  = 1'b0;
		rom_wr.value = req.write_data[2:0];

		// Remap the ROM and card RAM windows
		if (a[15:14] == 2'b01) begin
			rsp.physical_address = {2'b00, a} + ROM_OFFSET + {1'b0, rom_bank, 14'b0};
		end else if (a[15]) begin
			rsp.physical_address = {2'b11, ram_bank, a[14:0]};
		end else begin
			rsp.physical_address = {2'b00, a};
		end

		rsp.access_ok = 1'b1;

		// Decode the write area
		if (req.kind == KIND_WRITE) begin
			if (a < LCD_BASE) begin
				rsp.access_ok = 1'b0;
			end else if (a <= LCD_LAST) begin
				rsp.lcd_dirty  = 1'b1;
				rsp.lcd_offset = a[9:0];
			end else if (a >= ROMSEL_LO && a <= ROMSEL_HI) begin
				rom_wr.load = 1'b1;
			end else if (a >= KEY_LO && a <= IO_LAST) begin
				rsp.strobe_valid = 1'b1;
				rsp.key_strobe   = KEY_STROBE_TABLE[req.write_data[3:0]];
			end else if (a <= IO_LAST) begin
				rsp.access_ok = 1'b1;
			end else if (a <= ROM_LAST) begin
				rsp.access_ok = 1'b0;
			end else begin
				rsp.access_ok = card_ok;
			end
		end
	end

endmodule

// ----- hw/rtl/pocket_computer_memory_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pocket_computer_memory_decoder
// Address decoder and bank controller for an emulated pocket computer bus.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one CPU access per request (kind, cpu_address, write_data).
//   rsp  : one result per request, in order (physical address, access_ok,
//          display dirty mark, keyboard strobe).
//   APB  : ram_bank at 0x0, card_type at 0x4; write only while idle.
// Pipeline: a request taken into the input register is decoded, and its
//   result is captured in the result register, which drives rsp. Throughput
//   is one request per cycle while rsp.ready is high: the input register
//   feeds the decode logic, whose output lands in the result register.
// ROM bank writes take effect at the edge where the write leaves the input
//   register, so the very next request already sees the new bank.
// Reset clears both stages and the ROM bank; ram_bank resets to 0 and
//   card_type to 5 (32 KB card).
// Stall: when rsp.ready is low the result is held; the input register still
//   fills, and req.ready drops only when both stages hold a request.
// ----------------------------------------------------------------------------
module pocket_computer_memory_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	pcmd_req_if.sink                    req,
	pcmd_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcmd_pkg::PADDR_W-1:0] paddr,
	input  logic [pcmd_pkg::PDATA_W-1:0] pwdata,
	output logic [pcmd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import pcmd_pkg::*;

	logic       ram_bank_q;
	logic [2:0] card_type_q;
	logic [2:0] rom_bank_q;
	logic       cfg_wr;

	logic    valid_s1;
	req_t    req_s1;
	logic    valid_q;
	rsp_t    rsp_q;
	rsp_t    rsp_d;
	rom_wr_t rom_wr;
	logic    adv_s1;
	logic    take_req;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_bank_q  <= 1'b0;
			card_type_q <= CARD_TYPE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RAM_BANK:  ram_bank_q  <= pwdata[0];
				REG_CARD_TYPE: card_type_q <= pwdata[2:0];
				default:       ram_bank_q  <= ram_bank_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RAM_BANK:  prdata = {{(PDATA_W-1){1'b0}}, ram_bank_q};
			REG_CARD_TYPE: prdata = {{(PDATA_W-3){1'b0}}, card_type_q};
			default:       prdata = '0;
		endcase
	end

	// Pipeline handshake
	assign adv_s1    = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign take_req  = req.valid && req.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			req_s1.kind        <= req.kind;
			req_s1.cpu_address <= req.cpu_address;
			req_s1.write_data  <= req.write_data;
		end
	end

	pcmd_decode u_decode (
		.req       (req_s1),
		.rom_bank  (rom_bank_q),
		.ram_bank  (ram_bank_q),
		.card_type (card_type_q),
		.rsp       (rsp_d),
		.rom_wr    (rom_wr)
	);

	// Load the ROM bank as the write leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= 3'd0;
		end else if (adv_s1 && rom_wr.load) begin
			rom_bank_q <= rom_wr.value;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || rsp.ready) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid            = valid_q;
	assign rsp.physical_address = rsp_q.physical_address;
	assign rsp.access_ok        = rsp_q.access_ok;
	assign rsp.lcd_dirty        = rsp_q.lcd_dirty;
	assign rsp.lcd_offset       = rsp_q.lcd_offset;
	assign rsp.strobe_valid     = rsp_q.strobe_valid;
	assign rsp.key_strobe       = rsp_q.key_strobe;

endmodule

// ----- hw/rtl/pcmd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcmd_checker
// Port-level checks on the result channel of the memory decoder.
// ----------------------------------------------------------------------------
module pcmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [17:0] physical_address,
	input logic        access_ok,
	input logic        lcd_dirty,
	input logic [9:0]  lcd_offset,
	input logic        strobe_valid,
	input logic [7:0]  key_strobe
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(physical_address)
			&& $stable(access_ok) && $stable(lcd_dirty) && $stable(key_strobe))
		else $error("stalled result changed");

	// Side effects only on accepted, distinct writes
	a_side_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (lcd_dirty || strobe_valid) |-> access_ok && !(lcd_dirty && strobe_valid))
		else $error("side effect on refused access or both side effects");

	// Display dirty mark lies inside display memory
	a_lcd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && lcd_dirty |-> physical_address[17:10] == 8'h0A
			&& physical_address[9:0] == lcd_offset && lcd_offset <= 10'd891)
		else $error("display dirty mark out of range");

	// Idle side-effect fields read as zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (lcd_dirty || lcd_offset == 10'd0) && (strobe_valid || key_strobe == 8'd0))
		else $error("side-effect field set without its flag");

endmodule

bind pocket_computer_memory_decoder pcmd_checker u_pcmd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.physical_address (rsp.physical_address),
	.access_ok        (rsp.access_ok),
	.lcd_dirty        (rsp.lcd_dirty),
	.lcd_offset       (rsp.lcd_offset),
	.strobe_valid     (rsp.strobe_valid),
	.key_strobe       (rsp.key_strobe)
);
